/* rtl/dqer_pkg.sv */
// shared types and constants for the double-ended queue with even removal
`timescale 1ns / 1ps

package dqer_pkg;

  // default number of entries held by the queue
  localparam int unsigned DefaultCapacity = 16;

  // field widths of one transfer on either side
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // output tdata width, padded to whole bytes
  localparam int unsigned OutDataW = ((ValueW + CountW + 7) / 8) * 8;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CmdPushFront  = 3'd0,
    CmdPushBack   = 3'd1,
    CmdPopFront   = 3'd2,
    CmdPopBack    = 3'd3,
    CmdRemoveEven = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StPopWait,
    StScanRd,
    StScanChk,
    StFinish
  } state_e;

  // memory port controls from the sequencer to the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

/* rtl/deque_with_even_removal.sv */
// top level: bounded double-ended queue of signed words with even removal
// remove_even reads and then checks each entry held, one after another,
// through the single store port
// throughput: one item at a time; a new item is taken once the previous
// result sits in the output register
// reset clears head, count and handshake state; the entry store is not cleared
`timescale 1ns / 1ps

module deque_with_even_removal #(
  parameter int unsigned Capacity = dqer_pkg::DefaultCapacity
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dqer_pkg::ValueW-1:0]     s_axis_tdata,   // [31:0] value
  input  logic [dqer_pkg::CmdW-1:0]       s_axis_tuser,   // [2:0] command
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dqer_pkg::OutDataW-1:0]   m_axis_tdata,   // [31:0] popped_value,
                                                          // [36:32] count, rest zero
  output logic [dqer_pkg::StatusW-1:0]    m_axis_tuser    // [1:0] status
);
  import dqer_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  mem_ctrl_t         mem_ctrl;
  logic [AddrW-1:0]  mem_addr;
  logic [ValueW-1:0] mem_wdata;
  logic [ValueW-1:0] mem_rdata;

  logic              res_valid;
  logic              res_free;
  logic [ValueW-1:0] res_popped;
  status_e           res_status;
  logic [CntW-1:0]   res_count;
  logic [CountW-1:0] res_count_out;

  logic              out_valid_q;
  logic [ValueW-1:0] out_popped_q;
  logic [StatusW-1:0] out_status_q;
  logic [CountW-1:0] out_count_q;

  dqer_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_value_i   (s_axis_tdata),
    .res_valid_o  (res_valid),
    .res_free_i   (res_free),
    .res_popped_o (res_popped),
    .res_status_o (res_status),
    .res_count_o  (res_count),
    .mem_ctrl_o   (mem_ctrl),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  dqer_store #(
    .Capacity (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // count reported on five bits
  if (CntW >= CountW) begin : g_cnt_trunc
    assign res_count_out = res_count[CountW-1:0];
  end else begin : g_cnt_ext
    assign res_count_out = {{(CountW - CntW){1'b0}}, res_count};
  end

  // output register is free when empty or as its transfer completes
  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_popped_q <= res_popped;
      out_status_q <= res_status;
      out_count_q  <= res_count_out;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ValueW - CountW){1'b0}}, out_count_q, out_popped_q};
  assign m_axis_tuser  = out_status_q;

endmodule

/* rtl/dqer_ring.sv */
// shared ring position unit: (base + offset) modulo the capacity
`timescale 1ns / 1ps

module dqer_ring #(
  parameter int unsigned Capacity = 16
) (
  input  logic [$clog2(Capacity)-1:0] base_i,
  input  logic [$clog2(Capacity)-1:0] offset_i,
  output logic [$clog2(Capacity)-1:0] pos_o
);
  localparam int unsigned AddrW = $clog2(Capacity);

  logic [AddrW:0] sum;
  logic [AddrW:0] wrapped;

  // both operands stay below the capacity, so one compare and subtract wraps
  always_comb begin
    sum     = {1'b0, base_i} + {1'b0, offset_i};
    wrapped = sum - (AddrW + 1)'(Capacity);
    if (sum >= (AddrW + 1)'(Capacity)) begin
      pos_o = wrapped[AddrW-1:0];
    end else begin
      pos_o = sum[AddrW-1:0];
    end
  end

endmodule

/* rtl/dqer_store.sv */
// entry store: one shared address, synchronous write, registered read
`timescale 1ns / 1ps

module dqer_store #(
  parameter int unsigned Capacity = 16
) (
  input  logic                          clk_i,
  input  dqer_pkg::mem_ctrl_t           ctrl_i,
  input  logic [$clog2(Capacity)-1:0]   addr_i,
  input  logic [dqer_pkg::ValueW-1:0]   wdata_i,
  output logic [dqer_pkg::ValueW-1:0]   rdata_o
);
  import dqer_pkg::*;

  logic [ValueW-1:0] mem_q [Capacity];
  logic [ValueW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dqer_ctrl.sv */
// sequencer: decodes commands, keeps head and count, walks entries for even removal
`timescale 1ns / 1ps

module dqer_ctrl #(
  parameter int unsigned Capacity = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command side
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dqer_pkg::cmd_e                      in_cmd_i,
  input  logic [dqer_pkg::ValueW-1:0]         in_value_i,
  // result side
  output logic                                res_valid_o,
  input  logic                                res_free_i,
  output logic [dqer_pkg::ValueW-1:0]         res_popped_o,
  output dqer_pkg::status_e                   res_status_o,
  output logic [$clog2(Capacity+1)-1:0]       res_count_o,
  // entry store
  output dqer_pkg::mem_ctrl_t                 mem_ctrl_o,
  output logic [$clog2(Capacity)-1:0]         mem_addr_o,
  output logic [dqer_pkg::ValueW-1:0]         mem_wdata_o,
  input  logic [dqer_pkg::ValueW-1:0]         mem_rdata_i
);
  import dqer_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]   kept_q, kept_d;
  logic [ValueW-1:0] popped_q, popped_d;
  status_e           status_q, status_d;

  logic             full;
  logic             empty;
  logic [CntW-1:0]  count_m1;
  logic             scan_last;
  logic [AddrW-1:0] ring_offset;
  logic [AddrW-1:0] ring_pos;

  assign full      = (count_q == CntW'(Capacity));
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - CntW'(1);
  assign scan_last = (idx_q == count_m1[AddrW-1:0]);

  // shared ring position unit
  dqer_ring #(
    .Capacity (Capacity)
  ) u_ring (
    .base_i   (head_q),
    .offset_i (ring_offset),
    .pos_o    (ring_pos)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        if ((cmd_q == CmdPopFront || cmd_q == CmdPopBack) && !empty) begin
          state_d = StPopWait;
        end else if (cmd_q == CmdRemoveEven && !empty) begin
          state_d = StScanRd;
        end else begin
          state_d = StFinish;
        end
      end
      StPopWait: state_d = StFinish;
      StScanRd:  state_d = StScanChk;
      StScanChk: begin
        if (scan_last) state_d = StFinish;
        else           state_d = StScanRd;
      end
      StFinish: begin
        if (res_free_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs: handshake, ring offset select and memory controls
  always_comb begin
    in_ready_o        = 1'b0;
    res_valid_o       = 1'b0;
    ring_offset       = '0;
    mem_ctrl_o.wr_en  = 1'b0;
    mem_ctrl_o.rd_en  = 1'b0;
    mem_addr_o        = ring_pos;
    mem_wdata_o       = value_q;
    case (state_q)
      StIdle: in_ready_o = 1'b1;
      StExec: begin
        case (cmd_q)
          CmdPushFront: begin
            ring_offset      = AddrW'(Capacity - 1);
            mem_ctrl_o.wr_en = !full;
          end
          CmdPushBack: begin
            ring_offset      = count_q[AddrW-1:0];
            mem_ctrl_o.wr_en = !full;
          end
          CmdPopFront: begin
            // read at the head, the unit yields the new head
            ring_offset      = AddrW'(1);
            mem_addr_o       = head_q;
            mem_ctrl_o.rd_en = !empty;
          end
          CmdPopBack: begin
            ring_offset      = count_m1[AddrW-1:0];
            mem_ctrl_o.rd_en = !empty;
          end
          default: ring_offset = '0;
        endcase
      end
      StScanRd: begin
        ring_offset      = idx_q;
        mem_ctrl_o.rd_en = 1'b1;
      end
      StScanChk: begin
        // odd words move down to the kept position
        ring_offset      = kept_q[AddrW-1:0];
        mem_ctrl_o.wr_en = mem_rdata_i[0];
        mem_wdata_o      = mem_rdata_i;
      end
      StFinish: res_valid_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  // datapath register updates
  always_comb begin
    cmd_d    = cmd_q;
    value_d  = value_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    kept_d   = kept_q;
    popped_d = popped_q;
    status_d = status_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d    = in_cmd_i;
          value_d  = in_value_i;
          popped_d = '0;
          status_d = StatusOk;
        end
      end
      StExec: begin
        case (cmd_q)
          CmdPushFront, CmdPushBack: begin
            if (full) begin
              status_d = StatusFull;
            end else begin
              count_d = count_q + CntW'(1);
              if (cmd_q == CmdPushFront) head_d = ring_pos;
            end
          end
          CmdPopFront, CmdPopBack: begin
            if (empty) begin
              status_d = StatusEmpty;
            end else begin
              count_d = count_m1;
              if (cmd_q == CmdPopFront) head_d = ring_pos;
            end
          end
          CmdRemoveEven: begin
            idx_d  = '0;
            kept_d = '0;
          end
          default: cmd_d = cmd_q;
        endcase
      end
      StPopWait: popped_d = mem_rdata_i;
      StScanChk: begin
        if (mem_rdata_i[0]) kept_d = kept_q + CntW'(1);
        idx_d = idx_q + AddrW'(1);
        if (scan_last) count_d = mem_rdata_i[0] ? kept_q + CntW'(1) : kept_q;
      end
      default: popped_d = popped_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    value_q  <= value_d;
    idx_q    <= idx_d;
    kept_q   <= kept_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign res_popped_o = popped_q;
  assign res_status_o = status_q;
  assign res_count_o  = count_q;

endmodule
